// ===== hdl/polar_to_cartesian_macros.svh =====
// ----------------------------------------------------------------------------
// Polar to Cartesian converter: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef POLAR_TO_CARTESIAN_MACROS_SVH
`define POLAR_TO_CARTESIAN_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define P2C_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, switched off while reset is high.
`define P2C_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication that also holds through reset.
`define P2C_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== hdl/p2c_pkg.sv =====
// ----------------------------------------------------------------------------
// Polar to Cartesian converter: shared package
// Widths, fixed constants, the pipeline payload type and the arctangent table.
// ----------------------------------------------------------------------------
package p2c_pkg;

   localparam int IN_W  = 16;   // angle and radius width
   localparam int OUT_W = 24;   // x and y width
   localparam int VW    = 50;   // CORDIC x/y datapath, 32 fraction bits
   localparam int ZW    = 34;   // residual angle, 2^32 units per turn
   localparam int ATAN_ENTRIES = 24;

   // 1/K of an unbounded CORDIC in Q0.32.
   localparam logic [31:0] KINV = 32'h9B74EDA8;

   // Angle reduction: offset that makes any 16-bit angle non-negative
   // (a multiple of 360), and the reciprocal of 360 scaled by 2^24.
   localparam int ANG_OFFSET  = 33120;
   localparam int RECIP_360   = 46604;
   localparam int RECIP_SHIFT = 24;
   localparam int DEG_TURN    = 360;
   localparam int DEG_QUARTER = 90;

   // floor(2^32 / 360); the remainder of that division is 2^8, which the
   // start angle adds back as (256 * deg + HALF_DEG) / 360, rounded.
   localparam int BIN_PER_DEG = 11930464;
   localparam int HALF_DEG    = 180;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [1:0]           quad;
   } p2c_vec_type;

   // atan(2^-i) in units of 2^-32 turn.
   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] val;
      case (idx)
         0:       val = 32'h20000000;
         1:       val = 32'h12E4051E;
         2:       val = 32'h09FB385B;
         3:       val = 32'h051111D4;
         4:       val = 32'h028B0D43;
         5:       val = 32'h0145D7E1;
         6:       val = 32'h00A2F61E;
         7:       val = 32'h00517C55;
         8:       val = 32'h0028BE53;
         9:       val = 32'h00145F2F;
         10:      val = 32'h000A2F98;
         11:      val = 32'h000517CC;
         12:      val = 32'h00028BE6;
         13:      val = 32'h000145F3;
         14:      val = 32'h0000A2FA;
         15:      val = 32'h0000517D;
         16:      val = 32'h000028BE;
         17:      val = 32'h0000145F;
         18:      val = 32'h00000A30;
         19:      val = 32'h00000518;
         20:      val = 32'h0000028C;
         21:      val = 32'h00000146;
         22:      val = 32'h000000A3;
         23:      val = 32'h00000051;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/p2c_if.sv =====
// ----------------------------------------------------------------------------
// Polar to Cartesian converter: channel interfaces
// Valid/ready channels for requests (polar) and responses (Cartesian).
// ----------------------------------------------------------------------------
interface p2c_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [p2c_pkg::IN_W-1:0] angle_degrees;
   logic signed [p2c_pkg::IN_W-1:0] radius_value;

   modport source (output valid, angle_degrees, radius_value, input ready);
   modport sink   (input valid, angle_degrees, radius_value, output ready);
endinterface

interface p2c_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [p2c_pkg::OUT_W-1:0] x_coord;
   logic signed [p2c_pkg::OUT_W-1:0] y_coord;

   modport source (output valid, x_coord, y_coord, input ready);
   modport sink   (input valid, x_coord, y_coord, output ready);
endinterface

// ===== hdl/p2c_prep.sv =====
// ----------------------------------------------------------------------------
// Polar to Cartesian converter: front end
// Three stages: angle mod 360, quadrant split, start vector and start angle.
// ----------------------------------------------------------------------------
module p2c_prep (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [p2c_pkg::IN_W-1:0] in_angle,
   input  logic signed [p2c_pkg::IN_W-1:0] in_radius,
   output logic                            out_valid,
   input  logic                            out_ready,
   output p2c_pkg::p2c_vec_type            out_vec
);

   // Stage 0: offset angle, quotient by 360, absolute radius.
   logic        v0_ff, v0_in, rdy0;
   logic [16:0] off_ff, off_in;
   logic [7:0]  quot_ff, quot_in;
   logic [15:0] rad0_ff, rad0_in;

   // Stage 1: quadrant and residual degrees.
   logic        v1_ff, v1_in, rdy1;
   logic [1:0]  quad_ff, quad_in;
   logic [6:0]  deg_ff, deg_in;
   logic [15:0] rad1_ff, rad1_in;

   // Stage 2: start vector.
   logic                 v2_ff, v2_in, rdy2;
   p2c_pkg::p2c_vec_type vec_ff, vec_in;

   logic signed [17:0] ang_sum;
   logic [32:0]        prod_q;
   logic [16:0]        m_raw;
   logic [8:0]         m_deg;
   logic [14:0]        frac_num;
   logic [30:0]        prod_w;
   logic [31:0]        z_start;
   logic [47:0]        x_start;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign rdy0     = !v0_ff || rdy1;
   assign in_ready = rdy0;

   always_comb begin
      ang_sum = 18'(in_angle) + 18'(p2c_pkg::ANG_OFFSET);
      prod_q  = 33'(ang_sum[16:0]) * 33'(p2c_pkg::RECIP_360);
      v0_in   = rdy0 ? in_valid : v0_ff;
      if (in_valid && rdy0) begin
         off_in  = ang_sum[16:0];
         quot_in = prod_q[p2c_pkg::RECIP_SHIFT +: 8];
         rad0_in = in_radius[15] ? 16'(-in_radius) : 16'(in_radius);
      end else begin
         off_in  = off_ff;
         quot_in = quot_ff;
         rad0_in = rad0_ff;
      end
   end

   always_comb begin
      m_raw = off_ff - 17'(quot_ff) * 17'(p2c_pkg::DEG_TURN);
      if (m_raw >= 17'(p2c_pkg::DEG_TURN)) begin
         m_deg = 9'(m_raw - 17'(p2c_pkg::DEG_TURN));
      end else begin
         m_deg = m_raw[8:0];
      end
      v1_in = rdy1 ? v0_ff : v1_ff;
      if (v0_ff && rdy1) begin
         rad1_in = rad0_ff;
         if (m_deg >= 9'(3 * p2c_pkg::DEG_QUARTER)) begin
            quad_in = 2'd3;
            deg_in  = 7'(m_deg - 9'(3 * p2c_pkg::DEG_QUARTER));
         end else if (m_deg >= 9'(2 * p2c_pkg::DEG_QUARTER)) begin
            quad_in = 2'd2;
            deg_in  = 7'(m_deg - 9'(2 * p2c_pkg::DEG_QUARTER));
         end else if (m_deg >= 9'(p2c_pkg::DEG_QUARTER)) begin
            quad_in = 2'd1;
            deg_in  = 7'(m_deg - 9'(p2c_pkg::DEG_QUARTER));
         end else begin
            quad_in = 2'd0;
            deg_in  = m_deg[6:0];
         end
      end else begin
         rad1_in = rad1_ff;
         quad_in = quad_ff;
         deg_in  = deg_ff;
      end
   end

   // deg * 2^32 / 360 = deg * BIN_PER_DEG + (256 * deg) / 360, rounded.
   always_comb begin
      frac_num = {deg_ff, 8'b0} + 15'(p2c_pkg::HALF_DEG);
      prod_w   = 31'(frac_num) * 31'(p2c_pkg::RECIP_360);
      z_start  = 32'(deg_ff) * 32'(p2c_pkg::BIN_PER_DEG)
               + 32'(prod_w[p2c_pkg::RECIP_SHIFT +: 7]);
      x_start  = 48'(rad1_ff) * 48'(p2c_pkg::KINV);
      v2_in    = rdy2 ? v1_ff : v2_ff;
      if (v1_ff && rdy2) begin
         vec_in.x    = p2c_pkg::VW'(x_start);
         vec_in.y    = '0;
         vec_in.z    = p2c_pkg::ZW'(z_start);
         vec_in.quad = quad_ff;
      end else begin
         vec_in = vec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      off_ff  <= off_in;
      quot_ff <= quot_in;
      rad0_ff <= rad0_in;
      quad_ff <= quad_in;
      deg_ff  <= deg_in;
      rad1_ff <= rad1_in;
      vec_ff  <= vec_in;
   end

   assign out_valid = v2_ff;
   assign out_vec   = vec_ff;

endmodule

// ===== hdl/p2c_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// Polar to Cartesian converter: one CORDIC rotation stage
// Rotates the vector by +/- atan(2^-STAGE_IDX) and registers the result.
// ----------------------------------------------------------------------------
module p2c_cordic_stage #(
   parameter int STAGE_IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  p2c_pkg::p2c_vec_type in_vec,
   output logic                 out_valid,
   input  logic                 out_ready,
   output p2c_pkg::p2c_vec_type out_vec
);

   localparam logic signed [p2c_pkg::ZW-1:0] ATAN =
      p2c_pkg::ZW'(p2c_pkg::atan_turn(STAGE_IDX));

   logic                         valid_ff, valid_in;
   p2c_pkg::p2c_vec_type         vec_ff, vec_in;
   logic signed [p2c_pkg::VW-1:0] x_cur, y_cur, dx, dy;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      x_cur    = in_vec.x;
      y_cur    = in_vec.y;
      dx       = y_cur >>> STAGE_IDX;
      dy       = x_cur >>> STAGE_IDX;
      valid_in = in_ready ? in_valid : valid_ff;
      vec_in   = vec_ff;
      if (in_valid && in_ready) begin
         vec_in.quad = in_vec.quad;
         if (!in_vec.z[p2c_pkg::ZW-1]) begin
            vec_in.x = x_cur - dx;
            vec_in.y = y_cur + dy;
            vec_in.z = in_vec.z - ATAN;
         end else begin
            vec_in.x = x_cur + dx;
            vec_in.y = y_cur - dy;
            vec_in.z = in_vec.z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      vec_ff <= vec_in;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

// ===== hdl/p2c_finish.sv =====
// ----------------------------------------------------------------------------
// Polar to Cartesian converter: output stage
// Quadrant rotation, rounding to FRAC_BITS, saturation, response register.
// ----------------------------------------------------------------------------
module p2c_finish #(
   parameter int FRAC_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  p2c_pkg::p2c_vec_type             in_vec,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [p2c_pkg::OUT_W-1:0] out_x,
   output logic signed [p2c_pkg::OUT_W-1:0] out_y
);

   localparam int VW    = p2c_pkg::VW;
   localparam int OW    = p2c_pkg::OUT_W;
   localparam int SHIFT = 32 - FRAC_BITS;
   localparam logic signed [VW-1:0] HALF = VW'(1) << (SHIFT - 1);

   logic                 valid_ff, valid_in;
   logic signed [OW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [VW-1:0] fx, fy;

   // Round half up, then clamp to the output range.
   function automatic logic signed [OW-1:0] round_sat(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] t;
      logic signed [OW-1:0] r;
      t = (v + HALF) >>> SHIFT;
      if ((&t[VW-1:OW-1]) || !(|t[VW-1:OW-1])) begin
         r = t[OW-1:0];
      end else if (t[VW-1]) begin
         r = {1'b1, {(OW-1){1'b0}}};
      end else begin
         r = {1'b0, {(OW-1){1'b1}}};
      end
      return r;
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      case (in_vec.quad)
         2'd1: begin
            fx = -in_vec.y;
            fy = in_vec.x;
         end
         2'd2: begin
            fx = -in_vec.x;
            fy = -in_vec.y;
         end
         2'd3: begin
            fx = in_vec.y;
            fy = -in_vec.x;
         end
         default: begin
            fx = in_vec.x;
            fy = in_vec.y;
         end
      endcase
      valid_in = in_ready ? in_valid : valid_ff;
      if (in_valid && in_ready) begin
         x_in = round_sat(fx);
         y_in = round_sat(fy);
      end else begin
         x_in = x_ff;
         y_in = y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;

endmodule

// ===== hdl/polar_to_cartesian.sv =====
// ----------------------------------------------------------------------------
// Polar to Cartesian converter: top level
// Converts (angle in degrees, integer radius) to fixed-point (x, y) by CORDIC.
// ----------------------------------------------------------------------------
// The block takes one request per clock and returns one response per request,
// in order. Each request is an angle in whole degrees and a radius; a negative
// radius is used by magnitude and the angle is reduced modulo 360. The response
// holds x = r*cos(angle) and y = r*sin(angle) as signed values with FRAC_BITS
// fraction bits, rounded half up and clamped to the 24-bit range. Let S be
// CORDIC_STAGES capped at the 24 entries of the arctangent table. The pipeline
// has S + 4 register stages (three front-end stages for the angle reduction
// and the start vector, one per CORDIC rotation, and the output register),
// and with the response side ready one request is taken every cycle. Every
// stage holds its item while the stage after it is full, so a stall on the
// response side fills the bubbles first and only then drops req_ch.ready;
// that ready is combinational from rsp_ch.ready through the stage chain.
`include "polar_to_cartesian_macros.svh"

module polar_to_cartesian #(
   parameter int FRAC_BITS     = 8,
   parameter int CORDIC_STAGES = 16
) (
   input  logic           clock,
   input  logic           reset,
   p2c_req_if.sink        req_ch,
   p2c_rsp_if.source      rsp_ch
);

   // Rotations past the end of the arctangent table are not performed.
   localparam int STAGES_USED = (CORDIC_STAGES < p2c_pkg::ATAN_ENTRIES) ?
                                CORDIC_STAGES : p2c_pkg::ATAN_ENTRIES;

   // Bound on the residual angle after the last rotation, with margin.
   localparam logic signed [p2c_pkg::ZW-1:0] Z_BOUND =
      p2c_pkg::ZW'(p2c_pkg::atan_turn(STAGES_USED - 1)) <<< 1;

   // Element 0 is the front-end output; element i+1 is the output of
   // rotation stage i.
   p2c_pkg::p2c_vec_type cordic_vec [STAGES_USED+1];
   logic                 cordic_vld [STAGES_USED+1];
   logic                 cordic_rdy [STAGES_USED+1];

   // Front end: angle reduction, quadrant split, start vector |r| / K.
   p2c_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_angle  (req_ch.angle_degrees),
      .in_radius (req_ch.radius_value),
      .out_valid (cordic_vld[0]),
      .out_ready (cordic_rdy[0]),
      .out_vec   (cordic_vec[0])
   );

   // One registered rotation per stage; the residual angle steers each turn.
   for (genvar i = 0; i < STAGES_USED; i++) begin : g_rot
      p2c_cordic_stage #(
         .STAGE_IDX (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cordic_vld[i]),
         .in_ready  (cordic_rdy[i]),
         .in_vec    (cordic_vec[i]),
         .out_valid (cordic_vld[i+1]),
         .out_ready (cordic_rdy[i+1]),
         .out_vec   (cordic_vec[i+1])
      );
   end

   // Quadrant rotation by swap and negate, rounding, saturation, output.
   p2c_finish #(
      .FRAC_BITS (FRAC_BITS)
   ) u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cordic_vld[STAGES_USED]),
      .in_ready  (cordic_rdy[STAGES_USED]),
      .in_vec    (cordic_vec[STAGES_USED]),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_x     (rsp_ch.x_coord),
      .out_y     (rsp_ch.y_coord)
   );

   // Reset empties the response register.
   `P2C_ASSERT_ALWAYS(a_reset_empties, clock, reset, !rsp_ch.valid)

   // A response can only appear when the last rotation stage held an item.
   `P2C_ASSERT_IMPL(a_rsp_from_pipe, clock, reset, $rose(rsp_ch.valid),
                    $past(cordic_vld[STAGES_USED]))

   // The rotations must have driven the residual angle close to zero.
   `P2C_ASSERT_IMPL(a_residual_small, clock, reset, cordic_vld[STAGES_USED],
                    (cordic_vec[STAGES_USED].z <= Z_BOUND) &&
                    (cordic_vec[STAGES_USED].z >= -Z_BOUND))

endmodule

// ===== tb/tb_polar_to_cartesian.sv =====
// ----------------------------------------------------------------------------
// Polar to Cartesian converter: self-checking testbench
// Sends polar requests through the valid/ready request channel, predicts each
// Cartesian response with an independent CORDIC model and compares every
// response field by field, in order, under random idling and backpressure.
// ----------------------------------------------------------------------------

module tb_polar_to_cartesian;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [p2c_pkg::OUT_W-1:0] x_coord;
      logic signed [p2c_pkg::OUT_W-1:0] y_coord;
   } cart_point_type;

   class cart_scoreboard;
      int frac_bits;
      int rotations;
      cart_point_type pending_points[$];
      int requests_seen;
      int responses_checked;
      int clamped_coords;
      int errors;

      function new(int frac_bits_in, int rotations_in);
         frac_bits         = frac_bits_in;
         rotations         = rotations_in;
         requests_seen     = 0;
         responses_checked = 0;
         clamped_coords    = 0;
         errors            = 0;
      endfunction

      // atan(2^-i) in units of 2^-32 of a full turn.
      function longint turn_step(int idx);
         longint val;
         case (idx)
            0:       val = 64'h20000000;
            1:       val = 64'h12E4051E;
            2:       val = 64'h09FB385B;
            3:       val = 64'h051111D4;
            4:       val = 64'h028B0D43;
            5:       val = 64'h0145D7E1;
            6:       val = 64'h00A2F61E;
            7:       val = 64'h00517C55;
            8:       val = 64'h0028BE53;
            9:       val = 64'h00145F2F;
            10:      val = 64'h000A2F98;
            11:      val = 64'h000517CC;
            12:      val = 64'h00028BE6;
            13:      val = 64'h000145F3;
            14:      val = 64'h0000A2FA;
            15:      val = 64'h0000517D;
            16:      val = 64'h000028BE;
            17:      val = 64'h0000145F;
            18:      val = 64'h00000A30;
            19:      val = 64'h00000518;
            20:      val = 64'h0000028C;
            21:      val = 64'h00000146;
            22:      val = 64'h000000A3;
            default: val = 64'h00000051;
         endcase
         return val;
      endfunction

      // Round a Q.32 value to frac_bits fraction bits (half up) and clamp it.
      function logic signed [p2c_pkg::OUT_W-1:0] round_clamp(longint v);
         int     shift;
         longint r;
         shift = 32 - frac_bits;
         r     = v;
         if (shift > 0)
            r = (v + (longint'(1) <<< (shift - 1))) >>> shift;
         if (r > 64'sd8388607) begin
            r = 64'sd8388607;
            clamped_coords++;
         end else if (r < -64'sd8388608) begin
            r = -64'sd8388608;
            clamped_coords++;
         end
         return r[p2c_pkg::OUT_W-1:0];
      endfunction

      function cart_point_type rotate_polar(logic signed [p2c_pkg::IN_W-1:0] ang,
                                            logic signed [p2c_pkg::IN_W-1:0] rad);
         longint         a, r, m, quad, resid, x, y, z, dx, dy, fx, fy;
         longint         kinv;
         cart_point_type pt;
         kinv = 64'h9B74EDA8;
         a    = ang;
         r    = rad;
         if (r < 0)
            r = -r;
         m = a % 360;
         if (m < 0)
            m += 360;
         quad  = m / 90;
         resid = m - quad * 90;
         z = ((resid <<< 32) + 180) / 360;
         x = r * kinv;
         y = 0;
         for (int i = 0; i < rotations && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= turn_step(i);
            end else begin
               x += dx;
               y -= dy;
               z += turn_step(i);
            end
         end
         case (quad)
            1:       begin fx = -y; fy = x;  end
            2:       begin fx = -x; fy = -y; end
            3:       begin fx = y;  fy = -x; end
            default: begin fx = x;  fy = y;  end
         endcase
         pt.x_coord = round_clamp(fx);
         pt.y_coord = round_clamp(fy);
         return pt;
      endfunction

      function void note_request(logic signed [p2c_pkg::IN_W-1:0] ang,
                                 logic signed [p2c_pkg::IN_W-1:0] rad);
         pending_points.push_back(rotate_polar(ang, rad));
         requests_seen++;
      endfunction

      function void check_response(logic signed [p2c_pkg::OUT_W-1:0] x_got,
                                   logic signed [p2c_pkg::OUT_W-1:0] y_got);
         cart_point_type exp_pt;
         if (pending_points.size() == 0) begin
            $display("%0t: response with no request outstanding: x=%0d y=%0d",
                     $realtime, x_got, y_got);
            errors++;
            return;
         end
         exp_pt = pending_points.pop_front();
         responses_checked++;
         if (x_got !== exp_pt.x_coord) begin
            $display("%0t: x_coord mismatch: expected %0d, actual %0d",
                     $realtime, exp_pt.x_coord, x_got);
            errors++;
         end
         if (y_got !== exp_pt.y_coord) begin
            $display("%0t: y_coord mismatch: expected %0d, actual %0d",
                     $realtime, exp_pt.y_coord, y_got);
            errors++;
         end
      endfunction

      function int pending();
         return pending_points.size();
      endfunction
   endclass

   localparam int FRAC_BITS     = 8;
   localparam int CORDIC_STAGES = 16;
   // Cycles from the edge that accepts a request to the earliest edge that can
   // take its response, with the response side ready.
   localparam int LATENCY       = CORDIC_STAGES + 4;
   // Cycles without any handshake before the run is declared hung.
   localparam int STALL_LIMIT   = 2000;
   // Length of the deliberate response hold-off; well beyond the pipeline depth.
   localparam int HOLD_CYCLES   = 90;
   localparam int IDLE_PERCENT  = 21;

   logic clock;
   logic reset;

   p2c_req_if req_ch ();
   p2c_rsp_if rsp_ch ();

   polar_to_cartesian #(
      .FRAC_BITS     (FRAC_BITS),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cart_scoreboard sb = new(FRAC_BITS, CORDIC_STAGES);

   // Idling switches for both sides, and the request for a long hold-off that
   // the response process picks up on its own.
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   bit hold_off_req   = 1'b0;
   int directed_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Request and response monitors. All sampling happens at the rising edge;
   // the testbench only changes inputs at the falling edge, so the values seen
   // here are the ones the block sees at the same edge.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         sb.note_request(req_ch.angle_degrees, req_ch.radius_value);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response(rsp_ch.x_coord, rsp_ch.y_coord);
   end

   // Watchdog: any cycle with a handshake on either side restarts the count.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
               $realtime, STALL_LIMIT, sb.pending());
      $display("TEST FAILED");
      $finish;
   end

   // Response side. Ready is redrawn at every falling edge while idling is on.
   // A hold-off request holds ready low for as long as HOLD_CYCLES sets, counted
   // here, so the pipeline fills and the block has to stall its request side.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !receiver_idles || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Offers one request and waits until the block takes it. Any idle cycles
   // come before the request is raised, so valid never drops once it is up.
   task automatic send_request(input logic signed [p2c_pkg::IN_W-1:0] ang,
                               input logic signed [p2c_pkg::IN_W-1:0] rad);
      @(negedge clock);
      while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.angle_degrees <= ang;
      req_ch.radius_value  <= rad;
      do
         @(posedge clock);
      while (!req_ch.ready);
   endtask

   // Random requests. Most are fully random 16-bit fields, which toggles every
   // bit; some keep the angle near one or two turns so every quadrant and the
   // reduction around zero get dense coverage; a few use tiny radii where the
   // rounding of each coordinate matters most.
   task automatic send_random(input int count);
      logic signed [p2c_pkg::IN_W-1:0] ang;
      logic signed [p2c_pkg::IN_W-1:0] rad;
      int                              shape;
      for (int n = 0; n < count; n++) begin
         shape = $urandom_range(99);
         if (shape < 60) begin
            ang = p2c_pkg::IN_W'($urandom);
            rad = p2c_pkg::IN_W'($urandom);
         end else if (shape < 85) begin
            ang = p2c_pkg::IN_W'($urandom_range(1440) - 720);
            rad = p2c_pkg::IN_W'($urandom);
         end else begin
            ang = p2c_pkg::IN_W'($urandom);
            rad = p2c_pkg::IN_W'($urandom_range(8) - 4);
         end
         send_request(ang, rad);
      end
   endtask

   // Drops valid and waits until every accepted request has been answered.
   task automatic drain_responses();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   initial begin
      int dir_ang [$];
      int dir_rad [$];

      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.angle_degrees = '0;
      req_ch.radius_value  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests: the axes and quadrant edges, the wrap at a full
      // turn, negative and very large angles, zero and unit radii, the most
      // negative radius (taken by magnitude) and the largest magnitudes, which
      // drive the coordinates into the clamp.
      dir_ang = '{0, 0, 0, 90, 180, 270, 90, 180, 270, 359, 360, -1,
                  -90, -360, 32767, -32768, 45, 89, 1, 135, 225, 315, 720, -32767};
      dir_rad = '{0, 32767, -32768, 32767, -32767, 32767, -32768, -32768, -32768,
                  1000, 1000, 1000, -1, 100, 32767, -32768, -32768, 12345, 1,
                  32767, 32767, 32767, -5, 256};
      foreach (dir_ang[i]) begin
         send_request(p2c_pkg::IN_W'(dir_ang[i]), p2c_pkg::IN_W'(dir_rad[i]));
         directed_count++;
      end

      send_random(500);

      // Back up the whole pipeline: the receiver holds off while the sender
      // keeps offering back to back.
      sender_idles = 1'b0;
      hold_off_req = 1'b1;
      send_random(120);

      // Let the block run completely empty before going on.
      drain_responses();

      // A long stretch at full rate on both sides.
      receiver_idles = 1'b0;
      send_random(300);

      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      send_random(380);

      drain_responses();
      // Anything the block sends after this point has no request behind it.
      repeat (LATENCY + 10) @(posedge clock);

      $display("Run: %0d requests (%0d directed, the rest random over all angles and radii)",
               sb.requests_seen, directed_count);
      $display("Run: %0d responses checked, %0d clamped coordinates, errors: %0d",
               sb.responses_checked, sb.clamped_coords, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
